[design/boga_pkg.sv]
// Package for the bilinear offset-gradient accumulator.
// Holds field widths, derived datapath widths, the stage-to-stage struct and saturation.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package boga_pkg;

    localparam int TABLE_DEPTH = 4096;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_W  = 12;
    localparam int WORD_W = 32;
    localparam int OFF_W  = 24;
    localparam int SUM_W  = 48;
    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Coefficient width: one minus a fraction needs FRAC_BITS + 1 bits
    localparam int COEF_W  = FRAC_BITS + 1;
    // First-level product after the shift
    localparam int PROD_W  = WORD_W + 2;
    // Full-width products before the shift
    localparam int PA_W    = WORD_W + COEF_W + 1;
    localparam int PB_W    = PROD_W + COEF_W + 1;
    localparam int TERM_W  = PROD_W + 2;
    localparam int WG_W    = TERM_W + 2;
    localparam int IX_W    = PROD_W + 2;
    localparam int HI_W    = IX_W - FRAC_BITS;
    localparam int WHI_W   = WORD_W + HI_W;
    localparam int WLO_W   = WORD_W + COEF_W;
    localparam int DELTA_W = WHI_W + 1;
    localparam int ACC_W   = DELTA_W + 1;
    localparam int RAM_W   = 3 * SUM_W;

    localparam logic signed [ACC_W-1:0] ACC_MAX =
        {{(ACC_W-SUM_W+1){1'b0}}, {(SUM_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = ~ACC_MAX;

    typedef struct packed {
        logic                      valid;
        logic [IDX_W-1:0]          idx;
        logic signed [WG_W-1:0]    wg;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } boga_delta_t;

    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [ACC_W-1:0] v);
        priority if (v > ACC_MAX)
            return ACC_MAX[SUM_W-1:0];
        else if (v < ACC_MIN)
            return ACC_MIN[SUM_W-1:0];
        else
            return v[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[design/boga_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module boga_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                       wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

`default_nettype wire

[design/boga_grad.sv]
// Arithmetic pipeline: bilinear split of corner gradients and offset-gradient deltas.
// Four register stages; depends on boga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module boga_grad
    import boga_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     accept,
    input  wire logic [IDX_W-1:0]         entry_index,
    input  wire logic signed [WORD_W-1:0] weight_value,
    input  wire logic signed [OFF_W-1:0]  offset_x,
    input  wire logic signed [OFF_W-1:0]  offset_y,
    input  wire logic signed [WORD_W-1:0] grad_corner_00,
    input  wire logic signed [WORD_W-1:0] grad_corner_01,
    input  wire logic signed [WORD_W-1:0] grad_corner_10,
    input  wire logic signed [WORD_W-1:0] grad_corner_11,
    output boga_delta_t                   delta
);

    localparam logic [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;

    // Stage 1 combinational
    logic [COEF_W-1:0]        fx, fy, gx, gy;
    logic signed [WORD_W-1:0] g [4];
    logic [COEF_W-1:0]        ca [4];
    logic [COEF_W-1:0]        cb [4];
    logic signed [PA_W-1:0]   pa [4];
    logic signed [PA_W-1:0]   pb [4];

    // Stage 1 registers
    logic                     s1_valid_reg;
    logic [IDX_W-1:0]         s1_idx_reg;
    logic signed [WORD_W-1:0] s1_w_reg;
    logic [COEF_W-1:0]        s1_fy_reg, s1_gy_reg;
    logic signed [PROD_W-1:0] s1_a_reg [4];
    logic signed [PROD_W-1:0] s1_b_reg [4];

    // Stage 2
    logic [COEF_W-1:0]        c2 [4];
    logic signed [PB_W-1:0]   pw [4];
    logic signed [TERM_W-1:0] term [4];
    logic signed [WG_W-1:0]   s2_wg_next;
    logic signed [IX_W-1:0]   s2_ix_next, s2_iy_next;
    logic                     s2_valid_reg;
    logic [IDX_W-1:0]         s2_idx_reg;
    logic signed [WORD_W-1:0] s2_w_reg;
    logic signed [WG_W-1:0]   s2_wg_reg;
    logic signed [IX_W-1:0]   s2_ix_reg, s2_iy_reg;

    // Stage 3
    logic signed [WHI_W-1:0]  s3_hx_next, s3_hy_next;
    logic signed [WLO_W-1:0]  s3_lx_next, s3_ly_next;
    logic                     s3_valid_reg;
    logic [IDX_W-1:0]         s3_idx_reg;
    logic signed [WG_W-1:0]   s3_wg_reg;
    logic signed [WHI_W-1:0]  s3_hx_reg, s3_hy_reg;
    logic signed [WLO_W-1:0]  s3_lx_reg, s3_ly_reg;

    // Stage 4
    boga_delta_t              delta_next;
    boga_delta_t              delta_reg;
    logic                     delta_valid_reg;

    always_comb
    begin
        fx = {1'b0, offset_x[FRAC_BITS-1:0]};
        fy = {1'b0, offset_y[FRAC_BITS-1:0]};
        gx = ONE - fx;
        gy = ONE - fy;
        g[0] = grad_corner_00;
        g[1] = grad_corner_01;
        g[2] = grad_corner_10;
        g[3] = grad_corner_11;
        ca[0] = gx; ca[1] = gx; ca[2] = fx; ca[3] = fx;
        cb[0] = gy; cb[1] = fy; cb[2] = gy; cb[3] = fy;
        for (int i = 0; i < 4; i++)
        begin
            pa[i] = g[i] * $signed({1'b0, ca[i]});
            pb[i] = g[i] * $signed({1'b0, cb[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= entry_index;
        s1_w_reg   <= weight_value;
        s1_fy_reg  <= fy;
        s1_gy_reg  <= gy;
        for (int i = 0; i < 4; i++)
        begin
            s1_a_reg[i] <= pa[i][PROD_W+FRAC_BITS-1:FRAC_BITS];
            s1_b_reg[i] <= pb[i][PROD_W+FRAC_BITS-1:FRAC_BITS];
        end
    end

    always_comb
    begin
        c2[0] = s1_gy_reg; c2[1] = s1_fy_reg; c2[2] = s1_gy_reg; c2[3] = s1_fy_reg;
        for (int i = 0; i < 4; i++)
        begin
            pw[i]   = s1_a_reg[i] * $signed({1'b0, c2[i]});
            term[i] = pw[i][TERM_W+FRAC_BITS-1:FRAC_BITS];
        end
        s2_wg_next = WG_W'(term[0]) + WG_W'(term[1]) + WG_W'(term[2]) + WG_W'(term[3]);
        s2_ix_next = IX_W'(s1_b_reg[2]) + IX_W'(s1_b_reg[3])
                   - IX_W'(s1_b_reg[0]) - IX_W'(s1_b_reg[1]);
        s2_iy_next = IX_W'(s1_a_reg[1]) + IX_W'(s1_a_reg[3])
                   - IX_W'(s1_a_reg[0]) - IX_W'(s1_a_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        s2_idx_reg <= s1_idx_reg;
        s2_w_reg   <= s1_w_reg;
        s2_wg_reg  <= s2_wg_next;
        s2_ix_reg  <= s2_ix_next;
        s2_iy_reg  <= s2_iy_next;
    end

    // Split the gradient into integer and fraction parts so each product stays narrow
    always_comb
    begin
        s3_hx_next = s2_w_reg * $signed(s2_ix_reg[IX_W-1:FRAC_BITS]);
        s3_hy_next = s2_w_reg * $signed(s2_iy_reg[IX_W-1:FRAC_BITS]);
        s3_lx_next = s2_w_reg * $signed({1'b0, s2_ix_reg[FRAC_BITS-1:0]});
        s3_ly_next = s2_w_reg * $signed({1'b0, s2_iy_reg[FRAC_BITS-1:0]});
    end

    always_ff @(posedge clk)
    begin
        s3_idx_reg <= s2_idx_reg;
        s3_wg_reg  <= s2_wg_reg;
        s3_hx_reg  <= s3_hx_next;
        s3_hy_reg  <= s3_hy_next;
        s3_lx_reg  <= s3_lx_next;
        s3_ly_reg  <= s3_ly_next;
    end

    always_comb
    begin
        delta_next.valid = s3_valid_reg;
        delta_next.idx   = s3_idx_reg;
        delta_next.wg    = s3_wg_reg;
        delta_next.dx    = DELTA_W'(s3_hx_reg)
                         + DELTA_W'($signed(s3_lx_reg[WLO_W-1:FRAC_BITS]));
        delta_next.dy    = DELTA_W'(s3_hy_reg)
                         + DELTA_W'($signed(s3_ly_reg[WLO_W-1:FRAC_BITS]));
    end

    always_ff @(posedge clk)
    begin
        delta_reg <= delta_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_comb
    begin
        delta       = delta_reg;
        delta.valid = delta_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_valid_reg <= 1'b0;
        end
        else
        begin
            delta_valid_reg <= delta_next.valid;
        end
    end

endmodule

`default_nettype wire

[design/boga_accum.sv]
// Accumulator stage: store read-modify-write with forwarding, saturation, clearing pass.
// Depends on boga_pkg and boga_ram.
`timescale 1ns / 1ps
`default_nettype none

module boga_accum
    import boga_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire boga_delta_t        delta,
    output logic                    busy,
    output logic                    done,
    output logic [IDX_W-1:0]        result_index,
    output logic signed [SUM_W-1:0] weight_grad_sum,
    output logic signed [SUM_W-1:0] offset_x_grad_sum,
    output logic signed [SUM_W-1:0] offset_y_grad_sum
);

    logic                      clearing_reg;
    logic [ADDR_W-1:0]         clr_addr_reg;

    logic                      s5_valid_reg;
    logic                      s5_range_reg;
    logic [IDX_W-1:0]          s5_idx_reg;
    logic signed [WG_W-1:0]    s5_wg_reg;
    logic signed [DELTA_W-1:0] s5_dx_reg, s5_dy_reg;

    logic                      done_reg;
    logic                      wr_hit_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [SUM_W-1:0]   wg_sum_reg, dx_sum_reg, dy_sum_reg;

    logic [RAM_W-1:0]          rd_data;
    logic                      fwd;
    logic signed [SUM_W-1:0]   base_wg, base_dx, base_dy;
    logic signed [SUM_W-1:0]   wg_sum_next, dx_sum_next, dy_sum_next;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic [RAM_W-1:0]          wr_data;

    boga_ram #(
        .WIDTH (RAM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (ADDR_W'(delta.idx)),
        .rd_data (rd_data)
    );

    // The previous item writes in the same cycle this one's read is issued, so the read misses it: forward it
    always_comb
    begin
        fwd = wr_hit_reg && (idx_reg == s5_idx_reg);
        if (fwd)
        begin
            base_wg = wg_sum_reg;
            base_dx = dx_sum_reg;
            base_dy = dy_sum_reg;
        end
        else
        begin
            base_wg = rd_data[3*SUM_W-1:2*SUM_W];
            base_dx = rd_data[2*SUM_W-1:SUM_W];
            base_dy = rd_data[SUM_W-1:0];
        end
        if (s5_range_reg)
        begin
            wg_sum_next = sat_sum(ACC_W'(base_wg) + ACC_W'(s5_wg_reg));
            dx_sum_next = sat_sum(ACC_W'(base_dx) + ACC_W'(s5_dx_reg));
            dy_sum_next = sat_sum(ACC_W'(base_dy) + ACC_W'(s5_dy_reg));
        end
        else
        begin
            wg_sum_next = '0;
            dx_sum_next = '0;
            dy_sum_next = '0;
        end
        wr_en   = clearing_reg || (s5_valid_reg && s5_range_reg);
        wr_addr = clearing_reg ? clr_addr_reg : ADDR_W'(s5_idx_reg);
        wr_data = clearing_reg ? '0 : {wg_sum_next, dx_sum_next, dy_sum_next};
    end

    always_ff @(posedge clk)
    begin
        s5_range_reg <= (32'(delta.idx) < 32'(TABLE_DEPTH));
        s5_idx_reg   <= delta.idx;
        s5_wg_reg    <= delta.wg;
        s5_dx_reg    <= delta.dx;
        s5_dy_reg    <= delta.dy;
        idx_reg      <= s5_idx_reg;
        wg_sum_reg   <= wg_sum_next;
        dx_sum_reg   <= dx_sum_next;
        dy_sum_reg   <= dy_sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s5_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
            wr_hit_reg   <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
                begin
                    clearing_reg <= 1'b0;
                end
            end
            s5_valid_reg <= delta.valid;
            done_reg     <= s5_valid_reg;
            wr_hit_reg   <= s5_valid_reg && s5_range_reg;
        end
    end

    assign busy              = clearing_reg;
    assign done              = done_reg;
    assign result_index      = idx_reg;
    assign weight_grad_sum   = wg_sum_reg;
    assign offset_x_grad_sum = dx_sum_reg;
    assign offset_y_grad_sum = dy_sum_reg;

endmodule

`default_nettype wire

[design/bilinear_offset_grad_accumulate.sv]
// Top level of the bilinear offset-gradient accumulator.
// Depends on boga_pkg, boga_grad, boga_accum (and boga_ram below it).
//
// Channel   Handshake          Transfer when         Fields
// command   start / busy       start && !busy        entry_index .. grad_corner_11
// result    done (strobe)      done, one cycle       result_index .. offset_y_grad_sum
//
// One command transfer per cycle while busy is low; each result strobes once its command has passed the pipeline.
// The depth is set by two multiplier ranks for the bilinear split, one rank for the
// weight products, one add rank and two store stages (read, then add and write).
// After reset busy stays high while the clearing pass zeroes all TABLE_DEPTH entries of
// the store, one entry a cycle; afterwards busy stays low.
// The result side cannot stall; back-to-back commands on one entry forward through.
`timescale 1ns / 1ps
`default_nettype none

module bilinear_offset_grad_accumulate
    import boga_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [IDX_W-1:0]         entry_index,
    input  wire logic signed [WORD_W-1:0] weight_value,
    input  wire logic signed [OFF_W-1:0]  offset_x,
    input  wire logic signed [OFF_W-1:0]  offset_y,
    input  wire logic signed [WORD_W-1:0] grad_corner_00,
    input  wire logic signed [WORD_W-1:0] grad_corner_01,
    input  wire logic signed [WORD_W-1:0] grad_corner_10,
    input  wire logic signed [WORD_W-1:0] grad_corner_11,
    output logic                          done,
    output logic [IDX_W-1:0]              result_index,
    output logic signed [SUM_W-1:0]       weight_grad_sum,
    output logic signed [SUM_W-1:0]       offset_x_grad_sum,
    output logic signed [SUM_W-1:0]       offset_y_grad_sum
);

    logic        accept;
    boga_delta_t delta;

    // Take a command whenever the store is not being cleared
    assign accept = start && !busy;

    boga_grad u_grad (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .entry_index    (entry_index),
        .weight_value   (weight_value),
        .offset_x       (offset_x),
        .offset_y       (offset_y),
        .grad_corner_00 (grad_corner_00),
        .grad_corner_01 (grad_corner_01),
        .grad_corner_10 (grad_corner_10),
        .grad_corner_11 (grad_corner_11),
        .delta          (delta)
    );

    // Hold the store, add the deltas with saturation and drive the result strobe
    boga_accum u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .delta             (delta),
        .busy              (busy),
        .done              (done),
        .result_index      (result_index),
        .weight_grad_sum   (weight_grad_sum),
        .offset_x_grad_sum (offset_x_grad_sum),
        .offset_y_grad_sum (offset_y_grad_sum)
    );

endmodule

`default_nettype wire

[design/boga_checker.sv]
// Port-level checker for the bilinear offset-gradient accumulator, bound to the top level.
// Depends on boga_pkg.
`timescale 1ns / 1ps
`default_nettype none

module boga_checker
    import boga_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     start,
    input wire logic                     busy,
    input wire logic [IDX_W-1:0]         entry_index,
    input wire logic signed [WORD_W-1:0] weight_value,
    input wire logic signed [OFF_W-1:0]  offset_x,
    input wire logic signed [OFF_W-1:0]  offset_y,
    input wire logic signed [WORD_W-1:0] grad_corner_00,
    input wire logic signed [WORD_W-1:0] grad_corner_01,
    input wire logic signed [WORD_W-1:0] grad_corner_10,
    input wire logic signed [WORD_W-1:0] grad_corner_11,
    input wire logic                     done,
    input wire logic [IDX_W-1:0]         result_index,
    input wire logic signed [SUM_W-1:0]  weight_grad_sum,
    input wire logic signed [SUM_W-1:0]  offset_x_grad_sum,
    input wire logic signed [SUM_W-1:0]  offset_y_grad_sum
);

    a_busy_once: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !busy)
        else $error("busy rose after the clearing pass");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("result missing six cycles after command");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without a command");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result_index == $past(entry_index, 6)))
        else $error("result index does not match command");

endmodule

bind bilinear_offset_grad_accumulate boga_checker u_boga_checker (.*);

`default_nettype wire
